// ----- src/b64d_pkg.sv -----
`default_nettype none

package b64d_pkg;

   // Width of the capacity register and its value after reset
   localparam int CAP_W = 24;
   localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

   // Default width of the per-string byte counter
   localparam int COUNT_BITS_DEF = 24;

   // Most results that one request can cause
   localparam int BURST_MAX = 3;

   // Result status codes
   typedef enum logic [2:0] {
      ST_BYTE    = 3'd0,
      ST_DONE    = 3'd1,
      ST_BADCHAR = 3'd2,
      ST_PAD     = 3'd3,
      ST_LEN     = 3'd4,
      ST_OVER    = 3'd5
   } status_type;

   // One result
   typedef struct packed {
      logic [7:0] data;
      status_type status;
      logic       last;
   } result_type;

   // All results caused by one request, entry 0 goes out first
   typedef struct packed {
      logic [1:0]                 count;
      result_type [BURST_MAX-1:0] res;
   } burst_type;

endpackage

`default_nettype wire

// ----- src/b64d_core.sv -----
`default_nettype none

module b64d_core
   import b64d_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic             action,
   input  wire logic [7:0]       symbol,
   input  wire logic [CAP_W-1:0] capacity,
   output burst_type             burst
);

   // Compare width that holds both the counter and the capacity plus one
   localparam int LW = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

   localparam logic [5:0] SX_LOWER = 6'd26;
   localparam logic [5:0] SX_DIGIT = 6'd52;
   localparam logic [5:0] SX_PLUS  = 6'd62;
   localparam logic [5:0] SX_SLASH = 6'd63;

   typedef struct packed {
      logic       bad;
      logic       pad;
      logic [5:0] value;
   } sextet_type;

   // Character to six-bit value
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      logic [7:0] t;
      r = '0;
      t = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t = c - 8'h41;
         r.value = t[5:0];
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t = c - 8'h61;
         r.value = t[5:0] + SX_LOWER;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
         r.value = t[5:0] + SX_DIGIT;
      end else if (c == 8'h2B) begin
         r.value = SX_PLUS;
      end else if (c == 8'h2F) begin
         r.value = SX_SLASH;
      end else if (c == 8'h3D) begin
         r.pad = 1'b1;
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   logic [17:0]           sextet_ff, sextet_in;
   logic [1:0]            gpos_ff, gpos_in;
   logic [1:0]            pad_ff, pad_in;
   logic [15:0]           held_ff, held_in;
   logic [1:0]            held_cnt_ff, held_cnt_in;
   logic [COUNT_BITS-1:0] bytes_out_ff, bytes_out_in;
   logic                  error_ff, error_in;

   sextet_type            sx;
   logic [5:0]            sval;
   logic [1:0]            pad_n;
   logic [1:0]            add_n;
   logic [7:0]            b0, b1, b2;
   logic [LW-1:0]         sum;
   logic                  fits;
   logic                  fail_en;
   status_type            fail_st;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sextet_ff    <= '0;
         gpos_ff      <= '0;
         pad_ff       <= '0;
         held_ff      <= '0;
         held_cnt_ff  <= '0;
         bytes_out_ff <= '0;
         error_ff     <= 1'b0;
      end else begin
         sextet_ff    <= sextet_in;
         gpos_ff      <= gpos_in;
         pad_ff       <= pad_in;
         held_ff      <= held_in;
         held_cnt_ff  <= held_cnt_in;
         bytes_out_ff <= bytes_out_in;
         error_ff     <= error_in;
      end
   end

   // Group completion: bytes and the capacity check
   always_comb begin
      sx    = sextet_of(symbol);
      pad_n = sx.pad ? pad_ff + 2'd1 : pad_ff;
      sval  = sx.pad ? 6'd0 : sx.value;
      b0    = {sextet_ff[17:12], sextet_ff[11:10]};
      b1    = {sextet_ff[9:6], sextet_ff[5:2]};
      b2    = {sextet_ff[1:0], sval};
      add_n = 2'd3 - pad_n;
      sum   = LW'(bytes_out_ff) + LW'(add_n);
      fits  = (sum <= LW'(capacity)) && (sum <= LW'({COUNT_BITS{1'b1}}));
   end

   // One request against the string state
   always_comb begin
      sextet_in    = sextet_ff;
      gpos_in      = gpos_ff;
      pad_in       = pad_ff;
      held_in      = held_ff;
      held_cnt_in  = held_cnt_ff;
      bytes_out_in = bytes_out_ff;
      error_in     = error_ff;
      burst        = '0;
      fail_en      = 1'b0;
      fail_st      = ST_BADCHAR;

      if (fire && action) begin
         // end of string: length error for an open group, else held bytes then done (none after an error); clear state
         if (!error_ff) begin
            if (gpos_ff != 2'd0) begin
               burst.count  = 2'd1;
               burst.res[0] = '{data: 8'd0, status: ST_LEN, last: 1'b1};
            end else begin
               burst.count  = held_cnt_ff + 2'd1;
               burst.res[0] = (held_cnt_ff != 2'd0)
                  ? result_type'{data: held_ff[15:8], status: ST_BYTE, last: 1'b0}
                  : result_type'{data: 8'd0, status: ST_DONE, last: 1'b1};
               burst.res[1] = (held_cnt_ff == 2'd2)
                  ? result_type'{data: held_ff[7:0], status: ST_BYTE, last: 1'b0}
                  : result_type'{data: 8'd0, status: ST_DONE, last: 1'b1};
               burst.res[2] = '{data: 8'd0, status: ST_DONE, last: 1'b1};
            end
         end
         sextet_in    = '0;
         gpos_in      = '0;
         pad_in       = '0;
         held_in      = '0;
         held_cnt_in  = '0;
         bytes_out_in = '0;
         error_in     = 1'b0;
      end else if (fire && !error_ff) begin
         // one character
         if (sx.bad) begin
            fail_en = 1'b1;
            fail_st = ST_BADCHAR;
         end else if (pad_ff != 2'd0 && gpos_ff == 2'd0) begin
            fail_en = 1'b1;
            fail_st = ST_PAD;
         end else if (sx.pad && gpos_ff < 2'd2) begin
            fail_en = 1'b1;
            fail_st = ST_PAD;
         end else if (!sx.pad && pad_ff != 2'd0) begin
            fail_en = 1'b1;
            fail_st = ST_PAD;
         end else if (gpos_ff != 2'd3) begin
            sextet_in = {sextet_ff[11:0], sval};
            gpos_in   = gpos_ff + 2'd1;
            pad_in    = pad_n;
         end else begin
            sextet_in = '0;
            gpos_in   = '0;
            pad_in    = pad_n;
            if (!fits) begin
               fail_en = 1'b1;
               fail_st = ST_OVER;
            end else if (pad_n == 2'd0) begin
               bytes_out_in = bytes_out_ff + COUNT_BITS'(add_n);
               burst.count  = 2'd3;
               burst.res[0] = '{data: b0, status: ST_BYTE, last: 1'b0};
               burst.res[1] = '{data: b1, status: ST_BYTE, last: 1'b0};
               burst.res[2] = '{data: b2, status: ST_BYTE, last: 1'b0};
            end else begin
               // padded group waits for the end of string
               bytes_out_in = bytes_out_ff + COUNT_BITS'(add_n);
               held_in      = {b0, (add_n == 2'd2) ? b1 : 8'd0};
               held_cnt_in  = add_n;
            end
         end
      end

      // sticky error status
      if (fail_en) begin
         error_in     = 1'b1;
         burst.count  = 2'd1;
         burst.res[0] = '{data: 8'd0, status: fail_st, last: 1'b1};
      end
   end

   // No results while an error is pending for a string
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      (fire && !action && error_ff) |-> (burst.count == 2'd0))
      else $error("results given after a sticky error");

   // An error result leaves the error flag set
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (fire && !action && burst.count == 2'd1 && burst.res[0].last) |=> error_ff)
      else $error("error result without error flag");

   // End of string clears the per-string state
   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && action) |=> (gpos_ff == 2'd0 && bytes_out_ff == '0 && !error_ff))
      else $error("string state not cleared at end");

endmodule

`default_nettype wire

// ----- src/b64d_burst.sv -----
`default_nettype none

module b64d_burst
   import b64d_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire burst_type load_burst,
   input  wire logic      rsp_stall,
   output logic           rsp_valid,
   output result_type     head,
   output logic           free
);

   logic [1:0]                 count_ff, count_in;
   result_type [BURST_MAX-1:0] ent_ff, ent_in;
   logic                       take;

   // Drain one result per cycle while rsp_stall is low; reload when the last one leaves or the buffer is empty
   always_comb begin
      rsp_valid = (count_ff != 2'd0);
      head      = ent_ff[0];
      take      = rsp_valid && !rsp_stall;
      free      = (count_ff == 2'd0) || (count_ff == 2'd1 && take);
      count_in  = count_ff;
      ent_in    = ent_ff;
      if (load) begin
         count_in = load_burst.count;
         ent_in   = load_burst.res;
      end else if (take) begin
         count_in  = count_ff - 2'd1;
         ent_in[0] = ent_ff[1];
         ent_in[1] = ent_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   // A new burst never overwrites results still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> ((count_ff == 2'd0) || (count_ff == 2'd1 && take)))
      else $error("burst loaded over pending results");

   // A stalled burst keeps its count
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= 2'd2 && rsp_stall) |=> (count_ff == $past(count_ff)))
      else $error("pending results lost under stall");

endmodule

`default_nettype wire

// ----- src/base64_stream_decoder_unit.sv -----
`default_nettype none

// Streaming base64 decoder (standard alphabet). Each request is one
// character (req_action 0) or an end-of-string mark (req_action 1).
// Every four characters give three bytes as status 0 results; a padded
// final group ("x=" or "==") is held and its bytes come out at the end
// mark, followed by a done status with rsp_last set. Any error (bad
// character, misplaced padding, bad length, or more bytes than the
// capacity register allows) gives a single error status with rsp_last
// set, and later characters are dropped until the end mark. A request is
// taken every cycle while it causes at most one result and rsp_stall is
// low; a request causing more holds req_stall while the result buffer
// sends one result per cycle while rsp_stall is low. A request passes
// the input register and result buffer. The capacity register may be
// written at any time the decoder is idle; csr_ready is always high.
module base64_stream_decoder_unit
   import b64d_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_action,
   input  wire logic [7:0]       req_symbol,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_data,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_data
);

   logic             in_valid_ff, in_valid_in;
   logic             in_action_ff;
   logic [7:0]       in_symbol_ff;
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             accept;
   logic             fire;
   logic             free;
   burst_type        burst;
   result_type       head;

   // Capacity register
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Input register: request is decoded once the result buffer frees up
   always_comb begin
      fire        = in_valid_ff && free;
      req_stall   = in_valid_ff && !free;
      accept      = req_valid && !req_stall;
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_symbol_ff <= req_symbol;
      end
   end

   b64d_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .action   (in_action_ff),
      .symbol   (in_symbol_ff),
      .capacity (capacity_ff),
      .burst    (burst)
   );

   b64d_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .load_burst (burst),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .head       (head),
      .free       (free)
   );

   assign rsp_data   = head.data;
   assign rsp_status = head.status;
   assign rsp_last   = head.last;

endmodule

`default_nettype wire
